// ===== sv/fsc_pkg.sv =====
// fsc_pkg: shared types, command codes and symbol helpers for the four-square cipher.
// No dependencies.
package fsc_pkg;

  localparam int SYMS = 36;
  localparam int AW   = 6;

  localparam logic [5:0] LAST_SYM   = 6'd35;
  localparam logic [5:0] NUM_SYMS   = 6'd36;
  localparam logic [5:0] DIGIT_BASE = 6'd26;
  localparam logic [7:0] CHAR_X     = 8'h58;

  localparam logic [2:0] FN_BEGIN  = 3'd0;
  localparam logic [2:0] FN_KEY1   = 3'd1;
  localparam logic [2:0] FN_KEY2   = 3'd2;
  localparam logic [2:0] FN_FINISH = 3'd3;
  localparam logic [2:0] FN_ENC    = 3'd4;
  localparam logic [2:0] FN_DEC    = 3'd5;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] key_char;
    logic [7:0] first_char;
    logic [7:0] second_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_first;
    logic [7:0] out_second;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_DONE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       place1;
    logic       place2;
    logic       fill_mode;
    logic [5:0] fill_sym;
    logic       emit;
    logic       ready;
  } ctrl_t;

  // {valid, symbol index}
  function automatic logic [6:0] sym_of(input logic [7:0] ch);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'd0;
    r = 7'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = ch - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d = ch - 8'h61;
      r = {1'b1, d[5:0]};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30 + 8'd26;
      r = {1'b1, d[5:0]};
    end
    return r;
  endfunction

  // row start (row * 10) of a cell
  function automatic logic [5:0] row_base(input logic [5:0] p);
    logic [5:0] r;
    if (p >= 6'd30) r = 6'd30;
    else if (p >= 6'd20) r = 6'd20;
    else if (p >= 6'd10) r = 6'd10;
    else r = 6'd0;
    return r;
  endfunction

  // row of pa, column of pb
  function automatic logic [5:0] mix_cell(input logic [5:0] pa, input logic [5:0] pb);
    return row_base(pa) + (pb - row_base(pb));
  endfunction

  function automatic logic [7:0] sym_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < DIGIT_BASE) c = 8'h41 + {2'b00, s};
    else c = 8'h30 + {2'b00, s - DIGIT_BASE};
    return c;
  endfunction

  // plain grid cell, fillers K..N above the alphabet
  function automatic logic [7:0] plain_char(input logic [5:0] cidx);
    logic [7:0] c;
    if (cidx >= NUM_SYMS) c = 8'h41 + {2'b00, cidx - DIGIT_BASE};
    else c = sym_char(cidx);
    return c;
  endfunction

endpackage

// ===== sv/four_square_cipher_36.sv =====
// four_square_cipher_36: four-square cipher, 36 symbols, keyed grids in small RAMs.
// Encrypt/decrypt: accept enters ST_EMIT, which registers out_word/out_valid; busy while in it.
// Begin and keyword words leave busy low. Finish: 36-symbol sweep in ST_FILL, then ST_DONE.
// The receiver cannot stall; out_valid is a one-cycle strobe.
// Reset (sync, rst_n low) clears sequencer, masks, fill counts and ready; RAMs stay undefined.
// Depends on fsc_pkg, fsc_ctrl, fsc_keygrid, fsc_ram.
module four_square_cipher_36 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  fsc_pkg::in_word_t   in_word,
  output logic                busy,
  output logic                out_valid,
  output fsc_pkg::out_word_t  out_word
);
  import fsc_pkg::*;

  ctrl_t      ctrl;
  logic [6:0] key_s, a_s, b_s;
  logic [5:0] pa, pb, cell1, cell2, addr1, addr2, place_sym;
  logic [5:0] g1_q, g2_q, w1_q, w2_q;
  logic       all_used1, all_used2;

  logic [2:0] func_r;
  logic [5:0] cell1_r, cell2_r;
  logic       ok1_r, ok2_r;

  logic       out_valid_r;
  out_word_t  out_word_r, out_word_nxt;
  logic [5:0] dp1, dp2, dc1, dc2;

  assign key_s = sym_of(in_word.key_char);
  assign a_s   = sym_of(in_word.first_char);
  assign b_s   = sym_of(in_word.second_char);
  assign pa    = a_s[6] ? a_s[5:0] : 6'd0;
  assign pb    = b_s[6] ? b_s[5:0] : 6'd0;
  assign cell1 = mix_cell(pa, pb);
  assign cell2 = mix_cell(pb, pa);
  assign addr1 = (cell1 < NUM_SYMS) ? cell1 : 6'd0;
  assign addr2 = (cell2 < NUM_SYMS) ? cell2 : 6'd0;
  assign place_sym = ctrl.fill_mode ? ctrl.fill_sym : key_s[5:0];

  fsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_word.func),
    .key_ok    (key_s[6]),
    .all_used1 (all_used1),
    .all_used2 (all_used2),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  fsc_keygrid u_grid1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (ctrl.clear),
    .place_en  (ctrl.place1),
    .place_sym (place_sym),
    .cell_addr (addr1),
    .sym_addr  (pa),
    .cell_q    (g1_q),
    .where_q   (w1_q),
    .all_used  (all_used1)
  );

  fsc_keygrid u_grid2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (ctrl.clear),
    .place_en  (ctrl.place2),
    .place_sym (place_sym),
    .cell_addr (addr2),
    .sym_addr  (pb),
    .cell_q    (g2_q),
    .where_q   (w2_q),
    .all_used  (all_used2)
  );

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r  <= in_word.func;
      cell1_r <= cell1;
      cell2_r <= cell2;
      ok1_r   <= a_s[6];
      ok2_r   <= b_s[6];
    end
  end

  assign dp1 = ok1_r ? w1_q : 6'd0;
  assign dp2 = ok2_r ? w2_q : 6'd0;
  assign dc1 = mix_cell(dp1, dp2);
  assign dc2 = mix_cell(dp2, dp1);

  always_comb begin
    if (!ctrl.ready) begin
      out_word_nxt.out_first  = CHAR_X;
      out_word_nxt.out_second = CHAR_X;
    end else if (func_r == FN_ENC) begin
      out_word_nxt.out_first  = (cell1_r >= NUM_SYMS) ? plain_char(cell1_r) : sym_char(g1_q);
      out_word_nxt.out_second = (cell2_r >= NUM_SYMS) ? plain_char(cell2_r) : sym_char(g2_q);
    end else begin
      out_word_nxt.out_first  = plain_char(dc1);
      out_word_nxt.out_second = plain_char(dc2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/fsc_ram.sv =====
// fsc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/fsc_keygrid.sv =====
// fsc_keygrid: one keyed grid: cell store, position store, used mask and fill count.
// Depends on fsc_pkg and fsc_ram.
module fsc_keygrid (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clear,
  input  logic       place_en,
  input  logic [5:0] place_sym,
  input  logic [5:0] cell_addr,
  input  logic [5:0] sym_addr,
  output logic [5:0] cell_q,
  output logic [5:0] where_q,
  output logic       all_used
);
  import fsc_pkg::*;

  logic [SYMS-1:0] used_r, used_nxt;
  logic [5:0]      fill_r, fill_nxt;
  logic            do_place;

  assign do_place = place_en && !used_r[place_sym] && (fill_r < NUM_SYMS);

  always_comb begin
    used_nxt = used_r;
    fill_nxt = fill_r;
    if (clear) begin
      used_nxt = '0;
      fill_nxt = '0;
    end else if (do_place) begin
      used_nxt[place_sym] = 1'b1;
      fill_nxt = fill_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      fill_r <= '0;
    end else begin
      used_r <= used_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign all_used = &used_r;

  fsc_ram #(.WIDTH(AW), .DEPTH(SYMS)) u_cells (
    .clk   (clk),
    .we    (do_place),
    .waddr (fill_r),
    .wdata (place_sym),
    .raddr (cell_addr),
    .rdata (cell_q)
  );

  fsc_ram #(.WIDTH(AW), .DEPTH(SYMS)) u_where (
    .clk   (clk),
    .we    (do_place),
    .waddr (place_sym),
    .wdata (fill_r),
    .raddr (sym_addr),
    .rdata (where_q)
  );

endmodule

// ===== sv/fsc_ctrl.sv =====
// fsc_ctrl: command sequencer: begin clear, keyword placement, finish sweep, cipher read/emit.
// Depends on fsc_pkg.
module fsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          func,
  input  logic                key_ok,
  input  logic                all_used1,
  input  logic                all_used2,
  output logic                busy,
  output fsc_pkg::ctrl_t      ctrl
);
  import fsc_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ready_r, ready_nxt;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (func == FN_FINISH) state_nxt = ST_FILL;
          else if (func == FN_ENC || func == FN_DEC) state_nxt = ST_EMIT;
        end
      end
      ST_FILL: if (cnt_r == LAST_SYM) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt   = (state_r == ST_FILL) ? cnt_r + 6'd1 : 6'd0;
    ready_nxt = ready_r;
    if (accept && func == FN_BEGIN) ready_nxt = 1'b0;
    else if (state_r == ST_DONE) ready_nxt = all_used1 && all_used2;
  end

  always_comb begin
    busy           = (state_r != ST_IDLE);
    ctrl.clear     = accept && (func == FN_BEGIN);
    ctrl.place1    = (accept && func == FN_KEY1 && key_ok) || (state_r == ST_FILL);
    ctrl.place2    = (accept && func == FN_KEY2 && key_ok) || (state_r == ST_FILL);
    ctrl.fill_mode = (state_r == ST_FILL);
    ctrl.fill_sym  = cnt_r;
    ctrl.emit      = (state_r == ST_EMIT);
    ctrl.ready     = ready_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule
